[rtl/proximity_dedup_register_table_core_macros.svh]
// Assertion shorthands shared by the table core RTL.
`ifndef PROXIMITY_DEDUP_REGISTER_TABLE_CORE_MACROS_SVH
`define PROXIMITY_DEDUP_REGISTER_TABLE_CORE_MACROS_SVH

// Property checked at every rising edge, off while reset is asserted.
`define PDRT_ASSERT(label, clk_sig, rst_sig, prop, msg) \
	label: assert property (@(posedge clk_sig) disable iff (!rst_sig) prop) \
		else $error(msg);

// Expression that must never be true outside reset.
`define PDRT_NEVER(label, clk_sig, rst_sig, expr, msg) \
	label: assert property (@(posedge clk_sig) disable iff (!rst_sig) !(expr)) \
		else $error(msg);

`endif

[rtl/pdrt_pkg.sv]
`default_nettype none
package pdrt_pkg;

	localparam int STATUS_W = 2;
	localparam int IDX_W    = 6;
	localparam int CNT_W    = 7;
	localparam int THR_W    = 35;

	localparam logic [STATUS_W-1:0] STATUS_REGISTERED = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_DUPLICATE  = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_FULL       = 2'd2;

	localparam logic [THR_W-1:0] THR_RESET = 35'd65536;

	// Result of one distance test leaving the compare pipeline
	typedef struct packed {
		logic vld;
		logic near;
	} pdrt_hit_t;

endpackage
`default_nettype wire

[rtl/pdrt_ram.sv]
`default_nettype none
module pdrt_ram #(
	parameter int WIDTH = 34,
	parameter int DEPTH = 64
) (
	input  wire logic                                   clk,
	input  wire logic                                   we,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                       wdata,
	input  wire logic                                   re,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

[rtl/pdrt_dist.sv]
`default_nettype none
module pdrt_dist #(
	parameter int COORD_WIDTH = 16,
	parameter int AW          = 6
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              in_vld,
	input  wire logic [AW-1:0]                     in_idx,
	input  wire logic [COORD_WIDTH:0]              cx,
	input  wire logic [COORD_WIDTH:0]              cy,
	input  wire logic [2*(COORD_WIDTH+1)-1:0]      tbl,
	input  wire logic [pdrt_pkg::THR_W-1:0]        thr,
	output pdrt_pkg::pdrt_hit_t                    hit,
	output logic      [AW-1:0]                     hit_idx
);
	import pdrt_pkg::*;

	localparam int SW   = COORD_WIDTH + 1;
	localparam int DW   = COORD_WIDTH + 2;
	localparam int MW   = (DW > 31) ? 31 : DW;
	localparam int SQW  = 2 * MW;
	localparam int SUMW = SQW + 1;
	localparam int LIMW = THR_W + 2;
	localparam int CMPW = (SUMW > LIMW) ? SUMW : LIMW;

	logic [SW-1:0] tsx, tsy;
	logic [DW-1:0] dx, dy, adx, ady;
	logic          farx, fary;
	logic [SUMW-1:0] sum;
	logic [LIMW-1:0] lim;

	logic          vld_s1, vld_s2, vld_s3;
	logic [AW-1:0] idx_s1, idx_s2;
	logic [MW-1:0] ax_s1, ay_s1;
	logic          far_s1, far_s2;
	logic [SQW-1:0] sqx_s2, sqy_s2;
	logic          near_s3;

	assign tsx = tbl[2*SW-1:SW];
	assign tsy = tbl[SW-1:0];

	// Differences of doubled centers, then magnitudes
	assign dx  = {cx[SW-1], cx} - {tsx[SW-1], tsx};
	assign dy  = {cy[SW-1], cy} - {tsy[SW-1], tsy};
	assign adx = dx[DW-1] ? (~dx + 1'b1) : dx;
	assign ady = dy[DW-1] ? (~dy + 1'b1) : dy;
	// Magnitudes of 2^MW and above are never near
	assign farx = DW'(adx >> MW) != '0;
	assign fary = DW'(ady >> MW) != '0;

	assign sum = SUMW'(sqx_s2) + SUMW'(sqy_s2);
	assign lim = {thr, 2'b00};

	assign hit = {vld_s3, near_s3};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		idx_s1   <= in_idx;
		ax_s1    <= adx[MW-1:0];
		ay_s1    <= ady[MW-1:0];
		far_s1   <= farx | fary;

		idx_s2   <= idx_s1;
		sqx_s2   <= ax_s1 * ax_s1;
		sqy_s2   <= ay_s1 * ay_s1;
		far_s2   <= far_s1;

		hit_idx  <= idx_s2;
		near_s3  <= !far_s2 && (CMPW'(sum) < CMPW'(lim));
	end

endmodule
`default_nettype wire

[rtl/proximity_dedup_register_table_core.sv]
`default_nettype none
// Proximity de-duplicating segment table. Each item carries two segment
// endpoints (signed Q8.8); the block keeps the doubled centers of registered
// segments in a one-port-read, one-port-write RAM. A check-mode item (mode 0)
// is compared with stored entries in slot order, one RAM read per cycle, through
// a three-stage distance pipeline (difference and magnitude, squares, sum and
// compare against 4 x near_threshold_sq). The first entry strictly closer than
// the threshold makes the item a duplicate; otherwise the center is appended.
// Preload items (mode 1) append without a check. A full table drops an item that
// is no duplicate with status 2. The scan is a single read stream, so an item's
// time grows with the number of stored entries and shrinks when an early match
// ends the scan; with no scan the item goes straight from idle to done.
// The next item is taken while the last result still waits on out_stall; a
// result waiting that long holds back only the one after it. The table needs no
// clearing after reset: only slots below the stored count are ever read.
// Write near_threshold_sq only while no item is in flight.
module proximity_dedup_register_table_core #(
	parameter int TABLE_DEPTH = 64,
	parameter int COORD_WIDTH = 16
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,

	input  wire logic                             cfg_wr_en,
	input  wire logic [pdrt_pkg::THR_W-1:0]       cfg_wr_data,

	input  wire logic                             in_valid,
	output logic                                  in_stall,
	input  wire logic                             mode,
	input  wire logic signed [COORD_WIDTH-1:0]    first_x,
	input  wire logic signed [COORD_WIDTH-1:0]    first_y,
	input  wire logic signed [COORD_WIDTH-1:0]    second_x,
	input  wire logic signed [COORD_WIDTH-1:0]    second_y,

	output logic                                  out_valid,
	input  wire logic                             out_stall,
	output logic      [pdrt_pkg::STATUS_W-1:0]    status,
	output logic      [pdrt_pkg::IDX_W-1:0]       entry_index,
	output logic      [pdrt_pkg::CNT_W-1:0]       stored_count
);
	import pdrt_pkg::*;

	`include "proximity_dedup_register_table_core_macros.svh"

	localparam int SW   = COORD_WIDTH + 1;
	localparam int AW   = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CNTW = $clog2(TABLE_DEPTH + 1);
	// Drain count loaded on leaving SCAN; DRAIN waits until the last compare result is captured
	localparam logic [1:0] DRAIN_LAST = 2'd3;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_DONE
	} state_t;

	state_t           state_q;
	logic [CNTW-1:0]  cnt_q;
	logic [CNTW-1:0]  rd_ptr_q;
	logic [1:0]       drain_q;
	logic             found_q;
	logic [AW-1:0]    found_idx_q;
	logic [THR_W-1:0] thr_q;
	logic [SW-1:0]    cx_q, cy_q;

	logic             out_vld_q;
	logic [STATUS_W-1:0] status_q;
	logic [IDX_W-1:0] entry_index_q;
	logic [CNT_W-1:0] stored_count_q;

	logic             rd_vld_s1;
	logic [AW-1:0]    rd_idx_s1;

	logic [SW-1:0]    sum_x, sum_y;
	logic             accept;
	logic             out_free;
	logic             full;
	logic             issue;
	logic             new_hit;
	logic             ram_we;
	logic [2*SW-1:0]  ram_rdata;
	pdrt_hit_t        hit;
	logic [AW-1:0]    hit_idx;

	assign in_stall     = (state_q != ST_IDLE);
	assign accept       = in_valid && !in_stall;
	assign out_valid    = out_vld_q;
	assign status       = status_q;
	assign entry_index  = entry_index_q;
	assign stored_count = stored_count_q;

	// Doubled center: plain endpoint sums, exact
	assign sum_x = {first_x[COORD_WIDTH-1], first_x} + {second_x[COORD_WIDTH-1], second_x};
	assign sum_y = {first_y[COORD_WIDTH-1], first_y} + {second_y[COORD_WIDTH-1], second_y};

	assign out_free = !out_vld_q || !out_stall;
	assign full     = (cnt_q == CNTW'(TABLE_DEPTH));
	assign issue    = (state_q == ST_SCAN);
	// Only the first near entry in slot order counts
	assign new_hit  = hit.vld && hit.near && !found_q;
	assign ram_we   = (state_q == ST_DONE) && out_free && !found_q && !full;

	pdrt_ram #(
		.WIDTH(2 * SW),
		.DEPTH(TABLE_DEPTH)
	) u_center_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(cnt_q[AW-1:0]),
		.wdata({cx_q, cy_q}),
		.re   (issue),
		.raddr(rd_ptr_q[AW-1:0]),
		.rdata(ram_rdata)
	);

	pdrt_dist #(
		.COORD_WIDTH(COORD_WIDTH),
		.AW         (AW)
	) u_dist (
		.clk    (clk),
		.arst_n (arst_n),
		.in_vld (rd_vld_s1),
		.in_idx (rd_idx_s1),
		.cx     (cx_q),
		.cy     (cy_q),
		.tbl    (ram_rdata),
		.thr    (thr_q),
		.hit    (hit),
		.hit_idx(hit_idx)
	);

	// Tag travels beside the registered RAM read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_vld_s1 <= 1'b0;
		end else begin
			rd_vld_s1 <= issue;
		end
	end

	always_ff @(posedge clk) begin
		rd_idx_s1 <= rd_ptr_q[AW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= THR_RESET;
		end else if (cfg_wr_en) begin
			thr_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			cnt_q          <= '0;
			rd_ptr_q       <= '0;
			drain_q        <= '0;
			found_q        <= 1'b0;
			found_idx_q    <= '0;
			cx_q           <= '0;
			cy_q           <= '0;
			out_vld_q      <= 1'b0;
			status_q       <= STATUS_REGISTERED;
			entry_index_q  <= '0;
			stored_count_q <= '0;
		end else begin
			// Drop the waiting result once taken; DONE reloads it on its own
			if (out_vld_q && !out_stall && state_q != ST_DONE) begin
				out_vld_q <= 1'b0;
			end

			// Capture the first match from the compare pipeline
			if (new_hit) begin
				found_q     <= 1'b1;
				found_idx_q <= hit_idx;
			end

			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						cx_q     <= sum_x;
						cy_q     <= sum_y;
						found_q  <= 1'b0;
						rd_ptr_q <= '0;
						if (mode || (cnt_q == '0)) begin
							state_q <= ST_DONE;
						end else begin
							state_q <= ST_SCAN;
						end
					end
				end
				ST_SCAN: begin
					rd_ptr_q <= rd_ptr_q + 1'b1;
					// Stop issuing on the last stored entry or on a match
					if (new_hit || (CNTW'(rd_ptr_q + 1'b1) == cnt_q)) begin
						drain_q <= DRAIN_LAST;
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (drain_q == '0) begin
						state_q <= ST_DONE;
					end else begin
						drain_q <= drain_q - 1'b1;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						out_vld_q <= 1'b1;
						state_q   <= ST_IDLE;
						if (found_q) begin
							status_q       <= STATUS_DUPLICATE;
							entry_index_q  <= IDX_W'(found_idx_q);
							stored_count_q <= CNT_W'(cnt_q);
						end else if (full) begin
							status_q       <= STATUS_FULL;
							entry_index_q  <= '0;
							stored_count_q <= CNT_W'(cnt_q);
						end else begin
							status_q       <= STATUS_REGISTERED;
							entry_index_q  <= IDX_W'(cnt_q);
							stored_count_q <= CNT_W'(cnt_q + 1'b1);
							cnt_q          <= cnt_q + 1'b1;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	`PDRT_ASSERT(a_cnt_bound, clk, arst_n, cnt_q <= CNTW'(TABLE_DEPTH), "stored count over depth")
	`PDRT_ASSERT(a_hit_in_scan, clk, arst_n, hit.vld |-> (state_q == ST_SCAN || state_q == ST_DRAIN), "compare result outside scan")
	`PDRT_ASSERT(a_cnt_step, clk, arst_n, (cnt_q != $past(cnt_q)) |-> (out_vld_q && status_q == STATUS_REGISTERED), "count moved without a registered item")
	`PDRT_NEVER(a_full_write, clk, arst_n, ram_we && full, "table write while full")

endmodule
`default_nettype wire
